FILE: sv/packet_frame_parser_core_macros.svh
// Assertion macros shared by the packet frame parser RTL
`ifndef PACKET_FRAME_PARSER_CORE_MACROS_SVH
`define PACKET_FRAME_PARSER_CORE_MACROS_SVH

// Consequent checked in the same cycle
`define PFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the next cycle
`define PFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pfp_pkg.sv
// Types, codes and constants of the packet frame parser
`timescale 1ns / 1ps
`default_nettype none

package pfp_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MARKER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_TYPE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REJECT_TYPE  = 8'd3;

  localparam logic [15:0] FRAME_MARKER_RST = 16'hFFFF;
  localparam logic [15:0] DATA_TYPE_RST    = 16'hFFF1;
  localparam logic [15:0] ACK_TYPE_RST     = 16'hFFF2;
  localparam logic [15:0] REJECT_TYPE_RST  = 16'hFFF3;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_REJ  = 2'd2;

  localparam logic RK_PAYLOAD = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_PARTIAL   = 3'd4;
  localparam logic [2:0] ST_BAD_END   = 3'd5;

  localparam logic [8:0] COUNT_MAX = 9'd511;
  localparam logic [8:0] MIN_FRAME = 9'd8;

  // result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  client_code;
    logic [1:0]  packet_kind;
    logic [7:0]  segment_number;
    logic [15:0] reject_subcode;
    logic [7:0]  payload_length;
    logic [2:0]  status;
    logic        last_of_run;
  } result_t;

  // up to two results written per accepted byte
  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } res_push_t;

  // byte index of the first end identifier byte
  function automatic logic [8:0] end_offset(input logic [1:0] kind, input logic [7:0] len);
    logic [8:0] off;
    if (kind == KIND_ACK) begin
      off = 9'd6;
    end else if (kind == KIND_REJ) begin
      off = 9'd8;
    end else begin
      off = {1'b0, len} + 9'd7;
    end
    return off;
  endfunction

endpackage

`default_nettype wire

FILE: sv/pfp_in_if.sv
// Byte input channel of the packet frame parser
`timescale 1ns / 1ps
`default_nettype none

interface pfp_in_if import pfp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_end;

  modport source (output valid, output in_byte, output frame_end, input ready);
  modport sink (input valid, input in_byte, input frame_end, output ready);
endinterface

`default_nettype wire

FILE: sv/pfp_out_if.sv
// Result channel of the packet frame parser
`timescale 1ns / 1ps
`default_nettype none

interface pfp_out_if import pfp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  client_code;
  logic [1:0]  packet_kind;
  logic [7:0]  segment_number;
  logic [15:0] reject_subcode;
  logic [7:0]  payload_length;
  logic [2:0]  status;
  logic        last_of_run;

  modport source (
    output valid, output result_kind, output payload_byte, output client_code,
    output packet_kind, output segment_number, output reject_subcode,
    output payload_length, output status, output last_of_run, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input client_code,
    input packet_kind, input segment_number, input reject_subcode,
    input payload_length, input status, input last_of_run, output ready
  );
endinterface

`default_nettype wire

FILE: sv/pfp_cfg_if.sv
// Register write channel of the packet frame parser
`timescale 1ns / 1ps
`default_nettype none

interface pfp_cfg_if import pfp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/pfp_res_queue.sv
// Small result queue taking up to two results a cycle and giving one
`timescale 1ns / 1ps
`default_nettype none

module pfp_res_queue import pfp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire res_push_t push,
  input  wire logic      pop,
  output logic           room,
  output logic           head_valid,
  output result_t        head
);

  result_t mem [RES_DEPTH];

  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] count;

  assign room       = (count <= RES_CNT_W'(RES_DEPTH - 2));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + RES_PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
      count <= count + RES_CNT_W'(push.n) - RES_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: sv/packet_frame_parser_core.sv
// Packet frame parser: header capture, payload forwarding and frame summary
//
//   channel   role  transfer carries
//   bytes     sink  in_byte, frame_end
//   results   src   one payload byte result or one end of frame summary
//   cfg       sink  index, data (frame marker and the three type codes)
//
// One byte is taken per cycle while bytes.ready is high; its results land in a 4-entry
// queue the next cycle. A final byte that is also a payload byte gives two results.
// bytes.ready drops while the queue holds more than two results.
// Reset is synchronous; it restores the register defaults and clears the frame state.
// cfg.ready is high whenever reset is low.
`timescale 1ns / 1ps
`default_nettype none
`include "packet_frame_parser_core_macros.svh"

module packet_frame_parser_core import pfp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  pfp_in_if.sink    bytes,
  pfp_out_if.source results,
  pfp_cfg_if.sink   cfg
);

  logic [15:0] frame_marker;
  logic [15:0] data_type_code;
  logic [15:0] ack_type_code;
  logic [15:0] reject_type_code;

  logic [8:0]  byte_count;
  logic [7:0]  start_first_byte;
  logic        start_matches;
  logic [7:0]  client_store;
  logic [7:0]  type_high_byte;
  logic [1:0]  kind_store;
  logic        type_valid;
  logic [7:0]  segment_store;
  logic [15:0] subcode_store;
  logic [7:0]  length_store;
  logic [15:0] end_id_capture;

  logic [8:0]  byte_count_next;
  logic [7:0]  start_first_byte_next;
  logic        start_matches_next;
  logic [7:0]  client_store_next;
  logic [7:0]  type_high_byte_next;
  logic [1:0]  kind_store_next;
  logic        type_valid_next;
  logic [7:0]  segment_store_next;
  logic [15:0] subcode_store_next;
  logic [7:0]  length_store_next;
  logic [15:0] end_id_capture_next;

  logic        in_fire;
  logic        cfg_fire;
  logic        fwd;
  logic [8:0]  off;
  logic [15:0] type_word;
  logic [2:0]  st;
  logic        room;
  logic        head_valid;
  result_t     head;
  result_t     pay_res;
  result_t     sum_res;
  res_push_t   push;

  assign in_fire  = bytes.valid && bytes.ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign bytes.ready = !rst && room;
  assign cfg.ready   = !rst;

  // per-byte field capture
  always_comb begin
    start_first_byte_next = start_first_byte;
    start_matches_next    = start_matches;
    client_store_next     = client_store;
    type_high_byte_next   = type_high_byte;
    kind_store_next       = kind_store;
    type_valid_next       = type_valid;
    segment_store_next    = segment_store;
    subcode_store_next    = subcode_store;
    length_store_next     = length_store;
    end_id_capture_next   = end_id_capture;
    fwd                   = 1'b0;
    type_word             = {type_high_byte, bytes.in_byte};
    off                   = '0;

    if (byte_count == 9'd0) begin
      start_first_byte_next = bytes.in_byte;
    end else if (byte_count == 9'd1) begin
      start_matches_next = ({start_first_byte, bytes.in_byte} == frame_marker);
    end else if (byte_count == 9'd2) begin
      client_store_next = bytes.in_byte;
    end else if (byte_count == 9'd3) begin
      type_high_byte_next = bytes.in_byte;
    end else if (byte_count == 9'd4) begin
      type_valid_next = 1'b1;
      if (type_word == reject_type_code) begin
        kind_store_next = KIND_REJ;
      end else if (type_word == ack_type_code) begin
        kind_store_next = KIND_ACK;
      end else if (type_word == data_type_code) begin
        kind_store_next = KIND_DATA;
      end else begin
        type_valid_next = 1'b0;
        kind_store_next = KIND_DATA;
      end
    end else if (type_valid) begin
      case (kind_store)
        KIND_REJ: begin
          if (byte_count == 9'd5) begin
            subcode_store_next = {bytes.in_byte, 8'h00};
          end else if (byte_count == 9'd6) begin
            subcode_store_next = {subcode_store[15:8], bytes.in_byte};
          end else if (byte_count == 9'd7) begin
            segment_store_next = bytes.in_byte;
          end
        end
        KIND_ACK: begin
          if (byte_count == 9'd5) begin
            segment_store_next = bytes.in_byte;
          end
        end
        default: begin
          if (byte_count == 9'd5) begin
            segment_store_next = bytes.in_byte;
          end else if (byte_count == 9'd6) begin
            length_store_next = bytes.in_byte;
          end else if (byte_count < ({1'b0, length_store} + 9'd7) && start_matches) begin
            fwd = 1'b1;
          end
        end
      endcase
      off = end_offset(kind_store, length_store_next);
      if (byte_count == off) begin
        end_id_capture_next = {bytes.in_byte, end_id_capture[7:0]};
      end else if (byte_count == off + 9'd1) begin
        end_id_capture_next = {end_id_capture[15:8], bytes.in_byte};
      end
    end

    byte_count_next = (byte_count != COUNT_MAX) ? byte_count + 9'd1 : byte_count;
  end

  // end of frame status, first failing check wins
  always_comb begin
    if (byte_count_next < MIN_FRAME) begin
      st = ST_SHORT;
    end else if (!start_matches_next) begin
      st = ST_BAD_START;
    end else if (!type_valid_next) begin
      st = ST_BAD_TYPE;
    end else if (({1'b0, end_offset(kind_store_next, length_store_next)} + 10'd2) >
                 {1'b0, byte_count_next}) begin
      st = ST_PARTIAL;
    end else if (end_id_capture_next != frame_marker) begin
      st = ST_BAD_END;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    pay_res.result_kind    = RK_PAYLOAD;
    pay_res.payload_byte   = bytes.in_byte;
    pay_res.client_code    = client_store_next;
    pay_res.packet_kind    = kind_store_next;
    pay_res.segment_number = segment_store_next;
    pay_res.reject_subcode = '0;
    pay_res.payload_length = length_store_next;
    pay_res.status         = ST_OK;
    pay_res.last_of_run    = !bytes.frame_end;

    sum_res.result_kind    = RK_SUMMARY;
    sum_res.payload_byte   = '0;
    sum_res.status         = st;
    sum_res.last_of_run    = 1'b1;
    if (st == ST_SHORT || st == ST_BAD_START || st == ST_BAD_TYPE) begin
      sum_res.client_code    = '0;
      sum_res.packet_kind    = KIND_DATA;
      sum_res.segment_number = '0;
      sum_res.reject_subcode = '0;
      sum_res.payload_length = '0;
    end else begin
      sum_res.client_code    = client_store_next;
      sum_res.packet_kind    = kind_store_next;
      sum_res.segment_number = segment_store_next;
      sum_res.reject_subcode = (kind_store_next == KIND_REJ) ? subcode_store_next : 16'd0;
      sum_res.payload_length = (kind_store_next == KIND_DATA) ? length_store_next : 8'd0;
    end

    push.n      = in_fire ? (2'(fwd) + 2'(bytes.frame_end)) : 2'd0;
    push.first  = fwd ? pay_res : sum_res;
    push.second = sum_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_marker     <= FRAME_MARKER_RST;
      data_type_code   <= DATA_TYPE_RST;
      ack_type_code    <= ACK_TYPE_RST;
      reject_type_code <= REJECT_TYPE_RST;
    end else if (cfg_fire) begin
      unique case (cfg.index)
        REG_FRAME_MARKER: frame_marker     <= cfg.data;
        REG_DATA_TYPE:    data_type_code   <= cfg.data;
        REG_ACK_TYPE:     ack_type_code    <= cfg.data;
        REG_REJECT_TYPE:  reject_type_code <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_fire && bytes.frame_end)) begin
      byte_count       <= '0;
      start_first_byte <= '0;
      start_matches    <= 1'b0;
      client_store     <= '0;
      type_high_byte   <= '0;
      kind_store       <= KIND_DATA;
      type_valid       <= 1'b0;
      segment_store    <= '0;
      subcode_store    <= '0;
      length_store     <= '0;
      end_id_capture   <= '0;
    end else if (in_fire) begin
      byte_count       <= byte_count_next;
      start_first_byte <= start_first_byte_next;
      start_matches    <= start_matches_next;
      client_store     <= client_store_next;
      type_high_byte   <= type_high_byte_next;
      kind_store       <= kind_store_next;
      type_valid       <= type_valid_next;
      segment_store    <= segment_store_next;
      subcode_store    <= subcode_store_next;
      length_store     <= length_store_next;
      end_id_capture   <= end_id_capture_next;
    end
  end

  pfp_res_queue u_res_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (results.valid && results.ready),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  assign results.valid          = head_valid;
  assign results.result_kind    = head.result_kind;
  assign results.payload_byte   = head.payload_byte;
  assign results.client_code    = head.client_code;
  assign results.packet_kind    = head.packet_kind;
  assign results.segment_number = head.segment_number;
  assign results.reject_subcode = head.reject_subcode;
  assign results.payload_length = head.payload_length;
  assign results.status         = head.status;
  assign results.last_of_run    = head.last_of_run;

  `PFP_ASSERT_NEXT(a_frame_clears, in_fire && bytes.frame_end, byte_count == 9'd0, "frame state not cleared after final byte")
  `PFP_ASSERT_NEXT(a_count_steps, in_fire && !bytes.frame_end && byte_count != COUNT_MAX, byte_count == $past(byte_count) + 9'd1, "byte counter did not advance")
  `PFP_ASSERT_SAME(a_payload_ok, results.valid && results.result_kind == RK_PAYLOAD, results.status == ST_OK && results.reject_subcode == 16'd0, "payload result with summary fields set")
  `PFP_ASSERT_SAME(a_fwd_data, in_fire && fwd, kind_store == KIND_DATA && type_valid && start_matches, "payload forwarded outside a data packet")

endmodule

`default_nettype wire

FILE: sim/packet_frame_parser_core_tb.sv
// Self-checking testbench of packet_frame_parser_core: directed frames, then random frames
`timescale 1ns / 1ps

module packet_frame_parser_core_tb;
  import pfp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 28;

  typedef struct {
    logic [15:0] start_id;
    logic [15:0] ptype;
    logic [7:0]  client;
    logic [7:0]  seg;
    logic [7:0]  len;
    logic [15:0] sub;
    logic [15:0] end_id;
    int          cut;    // bytes kept, 0 keeps all
    int          tail;   // bytes after the end id
    bit          typed;
    logic [2:0]  status;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst;

  pfp_in_if  byte_ch ();
  pfp_out_if res_ch ();
  pfp_cfg_if cfg_ch ();

  packet_frame_parser_core dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  always #2 clk = ~clk;

  // register copy
  logic [15:0] bnd_id, code_data, code_ack, code_rej;
  // frame state copy
  logic [8:0]  cnt;
  logic [7:0]  sid_hi, cli, typ_hi, sgm, plen;
  logic [1:0]  knd;
  logic [15:0] subc, eid;
  bit          sid_ok, typ_ok;

  result_t     parsed_q[$];
  logic [7:0]  frame_bytes[$];
  result_t     seen_r, want_r;
  int          bad_results = 0;
  int          bytes_sent = 0;
  int          cycles = 0;
  bit          tx_quiet, rx_quiet, pressure, hold_req;
  bit          status_pinned;
  logic [2:0]  pinned_status;

  frame_row_t directed_rows[21] = '{
    '{16'hFFFF, 16'hFFF1, 8'h00, 8'h00, 8'd0,   16'h0000, 16'hFFFF, 0, 0,   1, ST_OK},
    '{16'hFFFF, 16'hFFF1, 8'hFF, 8'hFF, 8'd3,   16'h0000, 16'hFFFF, 0, 0,   0, ST_OK},
    '{16'hFFFF, 16'hFFF2, 8'h5A, 8'h00, 8'd0,   16'h0000, 16'hFFFF, 0, 0,   1, ST_OK},
    '{16'hFFFF, 16'hFFF3, 8'h01, 8'h80, 8'd0,   16'hFFFF, 16'hFFFF, 0, 0,   0, ST_OK},
    '{16'hFFFF, 16'hFFF3, 8'hA5, 8'hFF, 8'd0,   16'h0000, 16'hFFFF, 0, 0,   0, ST_OK},
    '{16'hFFFF, 16'hFFF1, 8'h11, 8'h22, 8'd4,   16'h0000, 16'hFFFF, 7, 0,   1, ST_SHORT},
    '{16'hFFFF, 16'hFFF1, 8'h11, 8'h22, 8'd4,   16'h0000, 16'hFFFF, 1, 0,   1, ST_SHORT},
    '{16'hFFFE, 16'hFFF1, 8'h33, 8'h44, 8'd2,   16'h0000, 16'hFFFF, 0, 0,   1, ST_BAD_START},
    '{16'h0000, 16'hFFF2, 8'h33, 8'h44, 8'd0,   16'h0000, 16'hFFFF, 0, 0,   1, ST_BAD_START},
    '{16'hFFFF, 16'h0000, 8'h55, 8'h66, 8'd0,   16'h0000, 16'hFFFF, 0, 0,   1, ST_BAD_TYPE},
    '{16'hFFFF, 16'hFFF0, 8'h55, 8'h66, 8'd0,   16'h0000, 16'hFFFF, 0, 3,   1, ST_BAD_TYPE},
    '{16'hFFFF, 16'hFFF1, 8'h77, 8'h88, 8'd5,   16'h0000, 16'hFFFF, 9, 0,   1, ST_PARTIAL},
    '{16'hFFFF, 16'hFFF3, 8'h77, 8'h88, 8'd0,   16'h1234, 16'hFFFF, 9, 0,   1, ST_PARTIAL},
    '{16'hFFFF, 16'hFFF1, 8'h99, 8'hAA, 8'd2,   16'h0000, 16'hFFFF, 10, 0,  1, ST_PARTIAL},
    '{16'hFFFF, 16'hFFF2, 8'hBB, 8'hCC, 8'd0,   16'h0000, 16'hFFFE, 0, 0,   1, ST_BAD_END},
    '{16'hFFFF, 16'hFFF1, 8'hBB, 8'hCC, 8'd1,   16'h0000, 16'h0000, 0, 0,   1, ST_BAD_END},
    '{16'hFFFF, 16'hFFF2, 8'hDD, 8'hEE, 8'd0,   16'h0000, 16'hFFFF, 0, 5,   1, ST_OK},
    '{16'hFFFF, 16'hFFF1, 8'h0F, 8'hF0, 8'd20,  16'h0000, 16'hFFFF, 0, 0,   1, ST_OK},
    '{16'hFFFF, 16'hFFF1, 8'hF0, 8'h0F, 8'd255, 16'h0000, 16'hFFFF, 0, 250, 1, ST_OK},
    '{16'h0000, 16'hFFF1, 8'h12, 8'h34, 8'd3,   16'h0000, 16'hFFFF, 5, 0,   1, ST_SHORT},
    '{16'h1234, 16'h0000, 8'h12, 8'h34, 8'd0,   16'h0000, 16'hFFFF, 0, 0,   1, ST_BAD_START}
  };

  logic [15:0] phase_regs[5][4] = '{
    '{16'h0000, 16'hFFFF, 16'h0000, 16'h8001},
    '{16'hA55A, 16'h5A5A, 16'h5A5A, 16'h0F0F},
    '{16'hFFFF, 16'h3C3C, 16'h3C3C, 16'h3C3C},
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{16'hFFFF, 16'hFFF1, 16'hFFF2, 16'hFFF3}
  };

  function automatic int end_pos();
    if (knd == KIND_ACK) return 6;
    if (knd == KIND_REJ) return 8;
    return 7 + int'(plen);
  endfunction

  task automatic clear_frame();
    cnt = '0; sid_hi = '0; sid_ok = 0; cli = '0; typ_hi = '0; knd = KIND_DATA;
    typ_ok = 0; sgm = '0; subc = '0; plen = '0; eid = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    int      idx;
    int      off;
    bit      fwd;
    result_t r;
    idx = int'(cnt);
    fwd = 0;
    case (idx)
      0: sid_hi = b;
      1: sid_ok = ({sid_hi, b} == bnd_id);
      2: cli = b;
      3: typ_hi = b;
      4: begin
        typ_ok = 1;
        if ({typ_hi, b} == code_rej) knd = KIND_REJ;
        else if ({typ_hi, b} == code_ack) knd = KIND_ACK;
        else if ({typ_hi, b} == code_data) knd = KIND_DATA;
        else begin
          typ_ok = 0;
          knd = KIND_DATA;
        end
      end
      default: if (typ_ok) begin
        if (knd == KIND_REJ) begin
          if (idx == 5) subc = {b, 8'h00};
          else if (idx == 6) subc[7:0] = b;
          else if (idx == 7) sgm = b;
        end else if (knd == KIND_ACK) begin
          if (idx == 5) sgm = b;
        end else begin
          if (idx == 5) sgm = b;
          else if (idx == 6) plen = b;
          else if (idx < 7 + int'(plen) && sid_ok) fwd = 1;
        end
        off = end_pos();
        if (idx == off) eid[15:8] = b;
        else if (idx == off + 1) eid[7:0] = b;
      end
    endcase
    if (cnt != COUNT_MAX) cnt = cnt + 9'd1;
    if (fwd) begin
      r = '0;
      r.result_kind = RK_PAYLOAD;
      r.payload_byte = b;
      r.client_code = cli;
      r.packet_kind = knd;
      r.segment_number = sgm;
      r.payload_length = plen;
      r.status = ST_OK;
      r.last_of_run = !fin;
      parsed_q.push_back(r);
    end
    if (fin) begin
      r = '0;
      r.result_kind = RK_SUMMARY;
      r.last_of_run = 1'b1;
      if (cnt < MIN_FRAME) r.status = ST_SHORT;
      else if (!sid_ok) r.status = ST_BAD_START;
      else if (!typ_ok) r.status = ST_BAD_TYPE;
      else if (end_pos() + 2 > int'(cnt)) r.status = ST_PARTIAL;
      else if (eid != bnd_id) r.status = ST_BAD_END;
      else r.status = ST_OK;
      if (status_pinned) begin
        r.status = pinned_status;
        status_pinned = 0;
      end
      if (r.status == ST_OK || r.status == ST_PARTIAL || r.status == ST_BAD_END) begin
        r.client_code = cli;
        r.packet_kind = knd;
        r.segment_number = sgm;
        r.reject_subcode = (knd == KIND_REJ) ? subc : 16'h0000;
        r.payload_length = (knd == KIND_DATA) ? plen : 8'h00;
      end
      parsed_q.push_back(r);
      clear_frame();
    end
  endtask

  task automatic set_config(input logic [15:0] bnd, dat, ack, rej);
    logic [15:0]          vals[4];
    logic [CFG_IDX_W-1:0] regs[4];
    vals = '{bnd, dat, ack, rej};
    regs = '{REG_FRAME_MARKER, REG_DATA_TYPE, REG_ACK_TYPE, REG_REJECT_TYPE};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[i];
      cfg_ch.data <= vals[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      case (regs[i])
        REG_FRAME_MARKER: bnd_id = vals[i];
        REG_DATA_TYPE:    code_data = vals[i];
        REG_ACK_TYPE:     code_ack = vals[i];
        REG_REJECT_TYPE:  code_rej = vals[i];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.in_byte <= b;
    byte_ch.frame_end <= fin;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
    parse_byte(b, fin);
  endtask

  task automatic send_frame(input frame_row_t r);
    frame_bytes = {};
    frame_bytes.push_back(r.start_id[15:8]);
    frame_bytes.push_back(r.start_id[7:0]);
    frame_bytes.push_back(r.client);
    frame_bytes.push_back(r.ptype[15:8]);
    frame_bytes.push_back(r.ptype[7:0]);
    if (r.ptype == code_rej) begin
      frame_bytes.push_back(r.sub[15:8]);
      frame_bytes.push_back(r.sub[7:0]);
      frame_bytes.push_back(r.seg);
    end else if (r.ptype == code_ack) begin
      frame_bytes.push_back(r.seg);
    end else if (r.ptype == code_data) begin
      frame_bytes.push_back(r.seg);
      frame_bytes.push_back(r.len);
      repeat (r.len) frame_bytes.push_back(8'($urandom));
    end else begin
      frame_bytes.push_back(r.seg);
    end
    frame_bytes.push_back(r.end_id[15:8]);
    frame_bytes.push_back(r.end_id[7:0]);
    repeat (r.tail) frame_bytes.push_back(8'($urandom));
    if (r.cut > 0 && r.cut < frame_bytes.size()) frame_bytes = frame_bytes[0:r.cut-1];
    status_pinned = r.typed;
    pinned_status = r.status;
    tx_quiet = pressure || ($urandom_range(0, 4) == 0);
    rx_quiet = ($urandom_range(0, 4) == 0);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic random_frame();
    frame_row_t r;
    int         sel;
    sel = $urandom_range(0, 99);
    r.start_id = bnd_id;
    r.end_id = bnd_id;
    r.client = 8'($urandom);
    r.seg = 8'($urandom);
    r.sub = 16'($urandom);
    r.cut = 0;
    r.typed = 0;
    r.status = ST_OK;
    case ($urandom_range(0, 2))
      0: r.ptype = code_data;
      1: r.ptype = code_ack;
      default: r.ptype = code_rej;
    endcase
    r.len = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 12));
    r.tail = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
    if ($urandom_range(0, 299) == 0) r.tail = 300;
    if (sel >= 96) begin
      r.start_id = 16'($urandom);
      r.ptype = 16'($urandom);
      r.end_id = 16'($urandom);
      r.cut = $urandom_range(1, 20);
    end else if (sel >= 88) begin
      r.cut = $urandom_range(1, 12);
    end else if (sel >= 82) begin
      r.end_id = 16'($urandom);
    end else if (sel >= 76) begin
      r.ptype = 16'($urandom);
    end else if (sel >= 70) begin
      r.start_id = 16'($urandom);
    end
    send_frame(r);
  endtask

  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic string show(input result_t r);
    return $sformatf("kind=%0d pay=%02h cli=%02h pk=%0d seg=%02h sub=%04h len=%02h st=%0d last=%0d",
                     r.result_kind, r.payload_byte, r.client_code, r.packet_kind,
                     r.segment_number, r.reject_subcode, r.payload_length, r.status,
                     r.last_of_run);
  endfunction

  // result sink with random stalls and one long hold-off
  initial begin
    int w;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      w = rx_quiet ? 0 : $urandom_range(0, 15);
      if (w != 0) begin
        res_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen_r.result_kind = res_ch.result_kind;
      seen_r.payload_byte = res_ch.payload_byte;
      seen_r.client_code = res_ch.client_code;
      seen_r.packet_kind = res_ch.packet_kind;
      seen_r.segment_number = res_ch.segment_number;
      seen_r.reject_subcode = res_ch.reject_subcode;
      seen_r.payload_length = res_ch.payload_length;
      seen_r.status = res_ch.status;
      seen_r.last_of_run = res_ch.last_of_run;
      if (parsed_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) $display("unexpected transfer: %s", show(seen_r));
      end else begin
        want_r = parsed_q.pop_front();
        if (seen_r.result_kind !== want_r.result_kind ||
            seen_r.payload_byte !== want_r.payload_byte ||
            seen_r.client_code !== want_r.client_code ||
            seen_r.packet_kind !== want_r.packet_kind ||
            seen_r.segment_number !== want_r.segment_number ||
            seen_r.reject_subcode !== want_r.reject_subcode ||
            seen_r.payload_length !== want_r.payload_length ||
            seen_r.status !== want_r.status ||
            seen_r.last_of_run !== want_r.last_of_run) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  exp %s", show(want_r));
            $display("  got %s", show(seen_r));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int phase_start;
    rst <= 1'b1;
    byte_ch.valid <= 1'b0;
    byte_ch.in_byte <= '0;
    byte_ch.frame_end <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_FRAME_MARKER;
    cfg_ch.data <= '0;
    bnd_id = FRAME_MARKER_RST;
    code_data = DATA_TYPE_RST;
    code_ack = ACK_TYPE_RST;
    code_rej = REJECT_TYPE_RST;
    clear_frame();
    pressure = 0;
    hold_req = 0;
    tx_quiet = 0;
    rx_quiet = 0;
    status_pinned = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults after reset
    foreach (directed_rows[i]) send_frame(directed_rows[i]);
    drain();

    for (int p = 0; p < 5; p++) begin
      if (p == 3)
        set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else
        set_config(phase_regs[p][0], phase_regs[p][1], phase_regs[p][2], phase_regs[p][3]);
      pressure = (p == 4);
      if (pressure) hold_req = 1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) random_frame();
      drain();
    end

    repeat (16) @(posedge clk);
    if (bad_results == 0 && parsed_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
